/* hdl/snal_pkg.sv */
// ----------------------------------------------------------------------------
// snal_pkg
// Shared constants and op codes of the suffix number allocator.
// ----------------------------------------------------------------------------
package snal_pkg;

  localparam int NUM_W       = 30;
  localparam int OP_W        = 3;
  localparam int WORD_W      = 32;
  localparam int WORD_BITS   = 5;
  localparam int TRACKED_DEF = 1024;

  localparam logic [NUM_W-1:0] LIMIT_NUMBER = NUM_W'(999999999);

  localparam logic [OP_W-1:0] OP_RESERVE  = 3'd0;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd1;
  localparam logic [OP_W-1:0] OP_TRY_USE  = 3'd2;
  localparam logic [OP_W-1:0] OP_SMALLEST = 3'd3;
  localparam logic [OP_W-1:0] OP_ALLOCATE = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

endpackage

/* hdl/snal_ram.sv */
// ----------------------------------------------------------------------------
// snal_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module snal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/suffix_number_allocator.sv */
// ----------------------------------------------------------------------------
// suffix_number_allocator
// Bitmap allocator for numeric name suffixes, with word-full summary flags
// and a register for the highest suffix seen.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid/in_ready    in_op, in_number
//  out_     output     out_valid/out_ready  out_granted, out_chosen_number,
//                                           out_saturated, out_highest_out
//
//  reserve, release, try_use, allocate hit: states chk, done, output register
//  smallest: srch, done (done alone with no free number); allocate with search:
//  chk, srch, done; spare op codes: done alone
//  clear, and reset: a sweep over all TRACKED/32 words of the bitmap ram
//  (32 for 1024), no transaction taken meanwhile
//  a stalled result holds in the output register; the next transaction is
//  taken meanwhile and waits only at its own result
module suffix_number_allocator #(
  parameter int TRACKED = snal_pkg::TRACKED_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [snal_pkg::OP_W-1:0]  in_op,
  input  logic [snal_pkg::NUM_W-1:0] in_number,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_granted,
  output logic [snal_pkg::NUM_W-1:0] out_chosen_number,
  output logic                       out_saturated,
  output logic [snal_pkg::NUM_W-1:0] out_highest_out
);

  import snal_pkg::*;

  localparam int NW = TRACKED / WORD_W;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [NUM_W-1:0] TRACKED_N = NUM_W'(TRACKED);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CHK,
    S_SRCH,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [NUM_W-1:0]  hi_r, hi_nxt;
  logic [NW-1:0]     full_r, full_nxt;
  logic [AW-1:0]     w_r, w_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              clrop_r, clrop_nxt;
  logic              res_g_r, res_g_nxt;
  logic [NUM_W-1:0]  res_c_r, res_c_nxt;
  logic              res_s_r, res_s_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_g_r, out_g_nxt;
  logic [NUM_W-1:0]  out_c_r, out_c_nxt;
  logic              out_s_r, out_s_nxt;
  logic [NUM_W-1:0]  out_h_r, out_h_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] rdata;

  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_W-1:0]    onehot;
  logic [AW-1:0]        num_word;
  logic                 n_in;
  logic [AW-1:0]        free_idx;
  logic                 any_free;
  logic [WORD_W-1:0]    eff;
  logic [WORD_BITS-1:0] zero_idx;
  logic [WORD_W-1:0]    new_word;
  logic [NUM_W:0]       cand;
  logic [NUM_W-1:0]     got;

  snal_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  // first word with a free number, bit 0 of word 0 counted as taken
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (!full_r[i]) begin
        free_idx = AW'(i);
        any_free = 1'b1;
      end
    end
  end

  always_comb begin
    eff = rdata;
    if (w_r == '0) begin
      eff[0] = 1'b1;
    end
    zero_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!eff[i]) begin
        zero_idx = WORD_BITS'(i);
      end
    end
  end

  assign bit_sel  = num_r[WORD_BITS-1:0];
  assign onehot   = WORD_W'(1) << bit_sel;
  assign num_word = num_r[WORD_BITS+AW-1:WORD_BITS];
  assign n_in     = (num_r < TRACKED_N);
  assign got      = NUM_W'({w_r, zero_idx});

  always_comb begin
    if (state_r == S_IDLE && in_op != OP_SMALLEST) begin
      mem_raddr = in_number[WORD_BITS+AW-1:WORD_BITS];
    end else begin
      mem_raddr = free_idx;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    num_nxt       = num_r;
    hi_nxt        = hi_r;
    full_nxt      = full_r;
    w_nxt         = w_r;
    clr_nxt       = clr_r;
    clrop_nxt     = clrop_r;
    res_g_nxt     = res_g_r;
    res_c_nxt     = res_c_r;
    res_s_nxt     = res_s_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_g_nxt     = out_g_r;
    out_c_nxt     = out_c_r;
    out_s_nxt     = out_s_r;
    out_h_nxt     = out_h_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    new_word      = '0;
    cand          = '0;

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (clr_r == AW'(NW - 1)) begin
          clr_nxt   = '0;
          state_nxt = clrop_r ? S_DONE : S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          num_nxt   = in_number;
          res_g_nxt = 1'b0;
          res_c_nxt = '0;
          res_s_nxt = 1'b0;
          case (in_op)
            OP_RESERVE, OP_RELEASE, OP_TRY_USE, OP_ALLOCATE: begin
              state_nxt = S_CHK;
            end
            OP_SMALLEST: begin
              if (any_free) begin
                w_nxt     = free_idx;
                state_nxt = S_SRCH;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_CLEAR: begin
              res_g_nxt = 1'b1;
              hi_nxt    = '0;
              full_nxt  = '0;
              clr_nxt   = '0;
              clrop_nxt = 1'b1;
              state_nxt = S_CLR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_CHK: begin
        mem_waddr = num_word;
        state_nxt = S_DONE;
        case (op_r)
          OP_RESERVE: begin
            new_word  = rdata | onehot;
            mem_wdata = new_word;
            if (n_in) begin
              mem_we             = 1'b1;
              full_nxt[num_word] = &(new_word | WORD_W'(num_word == '0));
            end
            if (num_r < LIMIT_NUMBER && num_r > hi_r) begin
              hi_nxt = num_r;
            end
            res_g_nxt = 1'b1;
          end
          OP_RELEASE: begin
            new_word  = rdata & ~onehot;
            mem_wdata = new_word;
            if (n_in) begin
              mem_we             = 1'b1;
              full_nxt[num_word] = &(new_word | WORD_W'(num_word == '0));
            end
            if (num_r != '0 && num_r == hi_r) begin
              hi_nxt = hi_r - NUM_W'(1);
            end
            res_g_nxt = 1'b1;
          end
          OP_TRY_USE, OP_ALLOCATE: begin
            new_word  = rdata | onehot;
            mem_wdata = new_word;
            if (n_in && !rdata[bit_sel]) begin
              mem_we             = 1'b1;
              full_nxt[num_word] = &(new_word | WORD_W'(num_word == '0));
              if (num_r > hi_r) begin
                hi_nxt = num_r;
              end
              res_g_nxt = 1'b1;
              res_c_nxt = num_r;
            end else if (op_r == OP_ALLOCATE) begin
              if (any_free) begin
                w_nxt     = free_idx;
                state_nxt = S_SRCH;
              end else begin
                // fallback past the bitmap, clamped at the limit
                if (num_r != '0 && num_r > hi_r) begin
                  cand = {1'b0, num_r};
                end else begin
                  cand = {1'b0, hi_r} + (NUM_W + 1)'(1);
                end
                res_g_nxt = 1'b1;
                if (cand >= {1'b0, LIMIT_NUMBER}) begin
                  res_c_nxt = LIMIT_NUMBER;
                  res_s_nxt = 1'b1;
                  hi_nxt    = LIMIT_NUMBER;
                end else begin
                  res_c_nxt = cand[NUM_W-1:0];
                  hi_nxt    = cand[NUM_W-1:0];
                end
              end
            end
          end
          default: begin
            res_g_nxt = 1'b0;
          end
        endcase
      end

      S_SRCH: begin
        new_word       = rdata | (WORD_W'(1) << zero_idx);
        mem_we         = 1'b1;
        mem_waddr      = w_r;
        mem_wdata      = new_word;
        full_nxt[w_r]  = &(new_word | WORD_W'(w_r == '0));
        if (got > hi_r) begin
          hi_nxt = got;
        end
        res_g_nxt = 1'b1;
        res_c_nxt = got;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_g_nxt     = res_g_r;
          out_c_nxt     = res_c_r;
          out_s_nxt     = res_s_r;
          out_h_nxt     = hi_r;
          clrop_nxt     = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      hi_r        <= '0;
      full_r      <= '0;
      clr_r       <= '0;
      clrop_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hi_r        <= hi_nxt;
      full_r      <= full_nxt;
      clr_r       <= clr_nxt;
      clrop_r     <= clrop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r    <= op_nxt;
    num_r   <= num_nxt;
    w_r     <= w_nxt;
    res_g_r <= res_g_nxt;
    res_c_r <= res_c_nxt;
    res_s_r <= res_s_nxt;
    out_g_r <= out_g_nxt;
    out_c_r <= out_c_nxt;
    out_s_r <= out_s_nxt;
    out_h_r <= out_h_nxt;
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_granted       = out_g_r;
  assign out_chosen_number = out_c_r;
  assign out_saturated     = out_s_r;
  assign out_highest_out   = out_h_r;

  // one transaction in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction taken while another is in flight");

  a_highest_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_highest_out <= LIMIT_NUMBER)
    else $error("highest suffix above limit");

  a_sat_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_granted && out_chosen_number == LIMIT_NUMBER)
    else $error("saturated result without grant at limit");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_chosen_number == '0)
    else $error("number reported without grant");

  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_CLR || state_r == S_CHK || state_r == S_SRCH)
    else $error("bitmap write outside a working state");

endmodule

/* tb/snal_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// snal_scoreboard_pkg
// Scoreboard for the suffix number allocator: keeps its own copy of the usage
// bitmap and the highest suffix, predicts one result per request and checks
// the results of the block in order against it.
// ----------------------------------------------------------------------------
package snal_scoreboard_pkg;

  import snal_pkg::*;

  typedef struct packed {
    logic             granted;
    logic [NUM_W-1:0] chosen_number;
    logic             saturated;
    logic [NUM_W-1:0] highest_out;
  } suffix_grant_t;

  class suffix_tracker_model;
    bit               used_map [TRACKED_DEF];
    logic [NUM_W-1:0] highest_seen;
    suffix_grant_t    pending_grants [$];
    int unsigned      mismatches;
    int unsigned      results_seen;

    function new();
      wipe();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void wipe();
      foreach (used_map[i]) used_map[i] = 1'b0;
      highest_seen = '0;
    endfunction

    function void raise_highest(logic [NUM_W-1:0] num);
      if (num > highest_seen) highest_seen = num;
    endfunction

    function bit claim_if_free(logic [NUM_W-1:0] num);
      if (num < TRACKED_DEF && !used_map[num]) begin
        used_map[num] = 1'b1;
        raise_highest(num);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // bit 0 is never handed out by the search
    function bit claim_lowest_free(output logic [NUM_W-1:0] got);
      got = '0;
      for (int i = 1; i < TRACKED_DEF; i++) begin
        if (!used_map[i]) begin
          used_map[i] = 1'b1;
          got = NUM_W'(i);
          raise_highest(got);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int free_count();
      int n;
      n = 0;
      for (int i = 1; i < TRACKED_DEF; i++) if (!used_map[i]) n++;
      return n;
    endfunction

    function int outstanding();
      return pending_grants.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [NUM_W-1:0] num);
      suffix_grant_t    grant;
      logic [NUM_W-1:0] lowest;
      logic [NUM_W:0]   fallback;
      grant = '0;
      case (op)
        OP_RESERVE: begin
          if (num < TRACKED_DEF) used_map[num] = 1'b1;
          if (num < LIMIT_NUMBER) raise_highest(num);
          grant.granted = 1'b1;
        end
        OP_RELEASE: begin
          if (num < TRACKED_DEF) used_map[num] = 1'b0;
          if (num != '0 && num == highest_seen) highest_seen = highest_seen - 1'b1;
          grant.granted = 1'b1;
        end
        OP_TRY_USE: begin
          if (claim_if_free(num)) begin
            grant.granted       = 1'b1;
            grant.chosen_number = num;
          end
        end
        OP_SMALLEST: begin
          if (claim_lowest_free(lowest)) begin
            grant.granted       = 1'b1;
            grant.chosen_number = lowest;
          end
        end
        OP_ALLOCATE: begin
          grant.granted = 1'b1;
          if (claim_if_free(num)) begin
            grant.chosen_number = num;
          end else if (claim_lowest_free(lowest)) begin
            grant.chosen_number = lowest;
          end else begin
            if (num != '0 && num > highest_seen) fallback = {1'b0, num};
            else fallback = {1'b0, highest_seen} + 1'b1;
            if (fallback >= {1'b0, LIMIT_NUMBER}) begin
              fallback        = {1'b0, LIMIT_NUMBER};
              grant.saturated = 1'b1;
            end
            highest_seen        = fallback[NUM_W-1:0];
            grant.chosen_number = highest_seen;
          end
        end
        OP_CLEAR: begin
          wipe();
          grant.granted = 1'b1;
        end
        default: ;
      endcase
      grant.highest_out = highest_seen;
      pending_grants.push_back(grant);
    endfunction

    function void check_result(logic granted, logic [NUM_W-1:0] chosen_number,
                               logic saturated, logic [NUM_W-1:0] highest_out);
      suffix_grant_t want;
      if (pending_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: granted %0b chosen %0d saturated %0b highest %0d",
                   granted, chosen_number, saturated, highest_out);
        return;
      end
      want = pending_grants.pop_front();
      results_seen++;
      if (granted !== want.granted || chosen_number !== want.chosen_number ||
          saturated !== want.saturated || highest_out !== want.highest_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d mismatch: granted %0b/%0b chosen %0d/%0d ",
                    "saturated %0b/%0b highest %0d/%0d (expected/actual)"},
                   results_seen, want.granted, granted, want.chosen_number, chosen_number,
                   want.saturated, saturated, want.highest_out, highest_out);
      end
    endfunction
  endclass

endpackage

/* tb/tb_suffix_number_allocator.sv */
// ----------------------------------------------------------------------------
// tb_suffix_number_allocator
// Drives marking, claiming, allocation and clear requests into the allocator
// with random gaps and stalls on both channels, including a full bitmap and
// the saturation limit, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module tb_suffix_number_allocator;

  timeunit 1ns;
  timeprecision 1ps;

  import snal_pkg::*;
  import snal_scoreboard_pkg::*;

  localparam logic [OP_W-1:0]  OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0]  OP_SPARE_HI = 3'd7;
  localparam logic [NUM_W-1:0] NUM_MAX     = '1;
  localparam int ITEM_TARGET  = 1750;
  localparam int HOLD_CYCLES  = 400;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_op;
  logic [NUM_W-1:0] in_number;
  logic             out_valid;
  logic             out_ready;
  logic             out_granted;
  logic [NUM_W-1:0] out_chosen_number;
  logic             out_saturated;
  logic [NUM_W-1:0] out_highest_out;

  bit hold_results;
  bit no_idle;
  int items_sent;

  suffix_tracker_model tracker;

  suffix_number_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_number         (in_number),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted       (out_granted),
    .out_chosen_number (out_chosen_number),
    .out_saturated     (out_saturated),
    .out_highest_out   (out_highest_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [NUM_W-1:0] pick_number();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return NUM_W'($urandom_range(0, 31));
    if (r < 55) return NUM_W'($urandom_range(0, TRACKED_DEF - 1));
    if (r < 63) return NUM_W'($urandom_range(TRACKED_DEF - 6, TRACKED_DEF + 6));
    if (r < 71) return NUM_W'($urandom_range(LIMIT_NUMBER - 3, LIMIT_NUMBER + 3));
    if (r < 79) return tracker.highest_seen;
    if (r < 84) return tracker.highest_seen + 1'b1;
    if (r < 94) return NUM_W'($urandom());
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return NUM_W'(1);
      2:       return NUM_W'(TRACKED_DEF - 1);
      3:       return NUM_W'(TRACKED_DEF);
      default: return NUM_MAX;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_mixed_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return OP_RESERVE;
    if (r < 35) return OP_RELEASE;
    if (r < 50) return OP_TRY_USE;
    if (r < 68) return OP_SMALLEST;
    if (r < 92) return OP_ALLOCATE;
    if (r < 94) return OP_CLEAR;
    if (r < 97) return OP_SPARE_LO;
    return OP_SPARE_HI;
  endfunction

  function automatic logic [OP_W-1:0] pick_fill_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_SMALLEST;
    if (r < 75) return OP_ALLOCATE;
    if (r < 85) return OP_RESERVE;
    if (r < 95) return OP_TRY_USE;
    return OP_RELEASE;
  endfunction

  function automatic logic [OP_W-1:0] pick_full_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_ALLOCATE;
    if (r < 55) return OP_SMALLEST;
    if (r < 70) return OP_TRY_USE;
    if (r < 85) return OP_RESERVE;
    return OP_RELEASE;
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_number <= num;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(op, num);
    if (op <= OP_CLEAR) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_result(out_granted, out_chosen_number, out_saturated, out_highest_out);
  end

  // result side back-pressure
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results && !held) begin
        held       = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    tracker      = new();
    hold_results = 1'b0;
    no_idle      = 1'b0;
    items_sent   = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = OP_RESERVE;
    in_number    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_request(OP_SPARE_LO, '0);
    send_request(OP_SPARE_HI, NUM_MAX);
    send_request(OP_RESERVE, '0);
    send_request(OP_SMALLEST, '0);
    send_request(OP_TRY_USE, NUM_W'(1));
    send_request(OP_TRY_USE, NUM_W'(TRACKED_DEF - 1));
    send_request(OP_TRY_USE, NUM_W'(TRACKED_DEF));
    send_request(OP_RESERVE, NUM_W'(TRACKED_DEF));
    send_request(OP_RELEASE, NUM_W'(TRACKED_DEF));
    send_request(OP_RELEASE, '0);
    send_request(OP_RESERVE, LIMIT_NUMBER - 1'b1);
    send_request(OP_RESERVE, LIMIT_NUMBER);
    send_request(OP_RESERVE, NUM_MAX);
    send_request(OP_ALLOCATE, NUM_W'(5));
    send_request(OP_ALLOCATE, NUM_W'(5));
    send_request(OP_ALLOCATE, '0);
    send_request(OP_RELEASE, LIMIT_NUMBER - 1'b1);
    send_request(OP_ALLOCATE, NUM_MAX);
    send_request(OP_RELEASE, NUM_MAX);
    send_request(OP_CLEAR, '0);
    send_request(OP_SMALLEST, NUM_MAX);
    send_request(OP_TRY_USE, '0);
    send_request(OP_RELEASE, NUM_W'(1));
    send_request(OP_ALLOCATE, NUM_W'(1));

    // mixed traffic, with one long hold on the result side
    while (items_sent < 400) begin
      if (items_sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (items_sent == 200) begin
        no_idle      = 1'b0;
        hold_results = 1'b1;
      end
      send_request(pick_mixed_op(), pick_number());
    end

    // sender pause, then fill the bitmap completely
    wait_drained();
    no_idle = 1'b0;
    while (tracker.free_count() != 0 && items_sent < 6000)
      send_request(pick_fill_op(), NUM_W'($urandom_range(0, TRACKED_DEF - 1)));

    // full bitmap: fallback values and the saturation limit
    send_request(OP_SMALLEST, '0);
    send_request(OP_ALLOCATE, NUM_W'(5000));
    send_request(OP_ALLOCATE, '0);
    send_request(OP_RESERVE, LIMIT_NUMBER - 1'b1);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_ALLOCATE, NUM_W'(3));
    send_request(OP_RELEASE, LIMIT_NUMBER);
    send_request(OP_ALLOCATE, LIMIT_NUMBER);
    send_request(OP_ALLOCATE, NUM_MAX);
    send_request(OP_RELEASE, '0);
    send_request(OP_ALLOCATE, '0);
    send_request(OP_TRY_USE, NUM_W'(7));
    repeat (80) begin
      if (tracker.free_count() == 0 || $urandom_range(0, 1) == 0)
        send_request(pick_full_op(), pick_number());
      else
        send_request(OP_SMALLEST, pick_number());
    end
    send_request(OP_CLEAR, pick_number());

    while (items_sent < ITEM_TARGET) begin
      if (items_sent % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_request(pick_mixed_op(), pick_number());
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
